### hdl/gavf_pkg.sv
package gavf_pkg;

    localparam int SYM_W              = 8;
    localparam int LANES_IN           = 4;
    localparam int MAX_HAPS_DEF       = 4;
    localparam int MAX_INSERT_RUN_DEF = 63;
    localparam int NUM_SYMS           = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int HAP_CNT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HAP_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_3     = 3'd5;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FLUSH
    } state_t;

    // per-column summary from the merge stage
    typedef struct packed {
        logic diff;
        logic allowed;
    } col_t;

    typedef struct packed {
        logic is_variant;
        logic is_insert_column;
        logic run_overflow;
        logic last_of_run;
        logic end_of_window;
    } res_t;

endpackage

### hdl/gavf_lane.sv
module gavf_lane (
    input  logic                      enable,
    input  logic [gavf_pkg::SYM_W-1:0] ref_symbol,
    input  logic [gavf_pkg::SYM_W-1:0] pred_symbol,
    output logic                      hit
);

    assign hit = enable && (pred_symbol != ref_symbol);

endmodule

### hdl/gavf_merge.sv
module gavf_merge #(
    parameter int LANES = gavf_pkg::LANES_IN
) (
    input  logic [LANES-1:0]              hits,
    input  logic [gavf_pkg::SYM_W-1:0]    ref_symbol,
    input  logic                          filter_enable,
    input  logic [gavf_pkg::NUM_SYMS-1:0] allowed_set,
    output gavf_pkg::col_t                col
);

    always_comb
    begin
        col.diff    = |hits;
        col.allowed = !filter_enable || allowed_set[ref_symbol];
    end

endmodule

### hdl/gavf_ctrl.sv
module gavf_ctrl #(
    parameter int MAX_INSERT_RUN = gavf_pkg::MAX_INSERT_RUN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           is_major,
    input  logic           last,
    input  gavf_pkg::col_t col,
    output logic           out_valid,
    input  logic           out_ready,
    output gavf_pkg::res_t out_res
);

    localparam int CNT_W = $clog2(MAX_INSERT_RUN + 1);
    localparam int IDX_W = (MAX_INSERT_RUN > 1) ? $clog2(MAX_INSERT_RUN) : 1;

    gavf_pkg::state_t          state_reg, state_next;
    logic [CNT_W-1:0]          run_len_reg, run_len_next;
    logic                      run_diff_reg, run_diff_next;
    logic                      at_start_reg, at_start_next;
    logic [MAX_INSERT_RUN-1:0] pending_reg, pending_next;
    logic                      tail_valid_reg, tail_valid_next;
    logic                      tail_var_reg, tail_var_next;
    logic                      tail_ovf_reg, tail_ovf_next;
    logic                      tail_diff_reg, tail_diff_next;
    logic                      eow_reg, eow_next;
    logic                      out_valid_reg, out_valid_next;
    gavf_pkg::res_t            out_reg, out_next;

    logic slot_free;
    logic accept;
    logic major;
    logic run_empty;
    logic run_full;
    logic last_held;
    logic need_flush;
    logic flush_done;

    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == gavf_pkg::ST_IDLE) && slot_free;
    assign accept     = in_valid && in_ready;
    assign major      = is_major || at_start_reg;
    assign run_empty  = (run_len_reg == '0);
    assign run_full   = (run_len_reg == CNT_W'(MAX_INSERT_RUN));
    assign last_held  = (run_len_reg == CNT_W'(1));
    // a closing major column flushes a nonempty run; a last insert always does
    assign need_flush = major ? !run_empty : last;
    assign flush_done = slot_free && (run_empty || (last_held && !tail_valid_reg));

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gavf_pkg::ST_IDLE:
            begin
                if (accept && need_flush)
                begin
                    state_next = gavf_pkg::ST_FLUSH;
                end
            end
            gavf_pkg::ST_FLUSH:
            begin
                if (flush_done)
                begin
                    state_next = gavf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gavf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        run_len_next    = run_len_reg;
        run_diff_next   = run_diff_reg;
        at_start_next   = at_start_reg;
        pending_next    = pending_reg;
        tail_valid_next = tail_valid_reg;
        tail_var_next   = tail_var_reg;
        tail_ovf_next   = tail_ovf_reg;
        tail_diff_next  = tail_diff_reg;
        eow_next        = eow_reg;
        out_valid_next  = slot_free ? 1'b0 : out_valid_reg;
        out_next        = out_reg;

        unique case (state_reg)
            gavf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (major)
                    begin
                        if (!run_empty)
                        begin
                            // hold the major result until the run is out
                            tail_valid_next = 1'b1;
                            tail_var_next   = col.diff && col.allowed;
                            tail_ovf_next   = 1'b0;
                            tail_diff_next  = col.diff;
                            eow_next        = last;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{col.diff && col.allowed, 1'b0, 1'b0, 1'b1, last};
                            run_diff_next  = last ? 1'b0 : col.diff;
                            at_start_next  = last;
                        end
                    end
                    else if (!run_full)
                    begin
                        pending_next[run_len_reg[IDX_W-1:0]] = col.allowed;
                        run_len_next    = run_len_reg + CNT_W'(1);
                        run_diff_next   = run_diff_reg || col.diff;
                        tail_valid_next = 1'b0;
                        tail_diff_next  = 1'b0;
                        eow_next        = 1'b1;
                    end
                    else if (last)
                    begin
                        // rejected last column goes out after the held run
                        tail_valid_next = 1'b1;
                        tail_var_next   = 1'b0;
                        tail_ovf_next   = 1'b1;
                        tail_diff_next  = 1'b0;
                        eow_next        = 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
                    end
                end
            end
            gavf_pkg::ST_FLUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (!run_empty)
                    begin
                        out_next = '{run_diff_reg && pending_reg[0], 1'b1, 1'b0,
                                     last_held && !tail_valid_reg,
                                     last_held && !tail_valid_reg && eow_reg};
                        pending_next = pending_reg >> 1;
                        run_len_next = run_len_reg - CNT_W'(1);
                    end
                    else
                    begin
                        out_next = '{tail_var_reg, tail_ovf_reg, tail_ovf_reg, 1'b1, eow_reg};
                    end
                    if (flush_done)
                    begin
                        run_diff_next = eow_reg ? 1'b0 : tail_diff_reg;
                        at_start_next = eow_reg;
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gavf_pkg::ST_IDLE;
            run_len_reg    <= '0;
            run_diff_reg   <= 1'b0;
            at_start_reg   <= 1'b1;
            tail_valid_reg <= 1'b0;
            eow_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_len_reg    <= run_len_next;
            run_diff_reg   <= run_diff_next;
            at_start_reg   <= at_start_next;
            tail_valid_reg <= tail_valid_next;
            eow_reg        <= eow_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pending_reg   <= pending_next;
        tail_var_reg  <= tail_var_next;
        tail_ovf_reg  <= tail_ovf_next;
        tail_diff_reg <= tail_diff_next;
        out_reg       <= out_next;
    end

endmodule

### hdl/gapped_alignment_variant_flagger.sv
// Gapped-alignment variant flagger.
// Input stream: one alignment column per transfer. s_tuser[0] marks a major
// column, s_tlast the final column of a window, s_tdata carries the reference
// symbol and four haplotype symbols. Output stream: one result per column;
// m_tlast marks the final result caused by one input column.
// A major column with no held inserts gives its result in the cycle after the
// transfer, and the block takes a new column every cycle while that holds and
// the receiver does not stall. Insert columns are silent and held (up to
// MAX_INSERT_RUN). Once the column that closes a run is taken, the input stays
// closed while the run drains through the single output register, one result
// per cycle unless the receiver stalls: each held insert, then the result of
// a closing major or rejected column itself.
// An insert arriving on a full run is rejected with an overflow result, at
// once, or after the flushed run when it ends the window.
// Registers are written through cfg_we/cfg_index/cfg_wdata. The user must
// write them only while idle; the block itself does not enforce it.
// Reset empties the run, starts a new window and restores hap_count to 1,
// the filter off and all allowed sets clear. When the receiver stalls the
// output register holds and s_tready drops until the result is taken.
module gapped_alignment_variant_flagger #(
    parameter int MAX_HAPS       = gavf_pkg::MAX_HAPS_DEF,
    parameter int MAX_INSERT_RUN = gavf_pkg::MAX_INSERT_RUN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // ref_symbol, pred_symbol_0, pred_symbol_1, pred_symbol_2, pred_symbol_3
    input  logic [39:0]                       s_tdata,
    // is_major
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // is_variant, zero fill
    output logic [7:0]                        m_tdata,
    // is_insert_column, run_overflow, end_of_window
    output logic [2:0]                        m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [gavf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gavf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int LANES = (MAX_HAPS < gavf_pkg::LANES_IN) ? MAX_HAPS : gavf_pkg::LANES_IN;

    logic [gavf_pkg::HAP_CNT_W-1:0] hap_count_reg;
    logic                           filter_enable_reg;
    logic [gavf_pkg::NUM_SYMS-1:0]  allowed_reg;
    logic [gavf_pkg::HAP_CNT_W-1:0] lanes_used;
    logic [LANES-1:0]               hits;
    gavf_pkg::col_t                 col;
    gavf_pkg::res_t                 res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hap_count_reg     <= gavf_pkg::HAP_CNT_W'(1);
            filter_enable_reg <= 1'b0;
            allowed_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gavf_pkg::CFG_HAP_COUNT:
                    hap_count_reg <= cfg_wdata[gavf_pkg::HAP_CNT_W-1:0];
                gavf_pkg::CFG_FILTER_ENABLE:
                    filter_enable_reg <= cfg_wdata[0];
                gavf_pkg::CFG_ALLOWED_0:
                    allowed_reg[63:0] <= cfg_wdata;
                gavf_pkg::CFG_ALLOWED_1:
                    allowed_reg[127:64] <= cfg_wdata;
                gavf_pkg::CFG_ALLOWED_2:
                    allowed_reg[191:128] <= cfg_wdata;
                gavf_pkg::CFG_ALLOWED_3:
                    allowed_reg[255:192] <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // zero lanes means one; cap at the lanes built
    always_comb
    begin
        if (hap_count_reg == '0)
        begin
            lanes_used = gavf_pkg::HAP_CNT_W'(1);
        end
        else if (hap_count_reg > gavf_pkg::HAP_CNT_W'(LANES))
        begin
            lanes_used = gavf_pkg::HAP_CNT_W'(LANES);
        end
        else
        begin
            lanes_used = hap_count_reg;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        gavf_lane u_lane (
            .enable      (lanes_used > gavf_pkg::HAP_CNT_W'(i)),
            .ref_symbol  (s_tdata[gavf_pkg::SYM_W-1:0]),
            .pred_symbol (s_tdata[gavf_pkg::SYM_W*(i+1) +: gavf_pkg::SYM_W]),
            .hit         (hits[i])
        );
    end

    gavf_merge #(
        .LANES (LANES)
    ) u_merge (
        .hits          (hits),
        .ref_symbol    (s_tdata[gavf_pkg::SYM_W-1:0]),
        .filter_enable (filter_enable_reg),
        .allowed_set   (allowed_reg),
        .col           (col)
    );

    gavf_ctrl #(
        .MAX_INSERT_RUN (MAX_INSERT_RUN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .is_major  (s_tuser[0]),
        .last      (s_tlast),
        .col       (col),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {7'b0, res.is_variant};
    assign m_tuser = {res.end_of_window, res.run_overflow, res.is_insert_column};
    assign m_tlast = res.last_of_run;

endmodule

### hdl/gavf_checker.sv
module gavf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // no column is taken while a result waits
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");

    a_eow_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("end of window without last of run");

    a_overflow_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && !m_tdata[0])
        else $error("overflow result not a clear insert column");

endmodule

bind gapped_alignment_variant_flagger gavf_checker u_gavf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
